// File: hw/rtl/c3f_pkg.sv
// shared types, constants and helpers of the 3x3 rgb convolution filter
package c3f_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = NUM_CH * CH_W;
  localparam int KSIZE     = 3;
  localparam int TAPS      = KSIZE * KSIZE;
  localparam int DIM_W     = 12;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 17;
  localparam int COLSUM_W  = PROD_W + 2;
  localparam int SUM_W     = COLSUM_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd4;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] ROW_LIMIT  = 12'd2048;
  localparam logic [DIM_W-1:0] ROW_SAT    = 12'd4095;

  localparam logic [CFG_W-1:0] COEF_TOP_RST = 24'h000000;
  localparam logic [CFG_W-1:0] COEF_MID_RST = 24'h000100;
  localparam logic [CFG_W-1:0] COEF_BOT_RST = 24'h000000;

  localparam logic signed [SUM_W-1:0] CHAN_MAX = 21'sd255;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } tap_mask_t;

  function automatic chan_t clamp_chan(input logic signed [SUM_W-1:0] s);
    chan_t r;
    if (s < 0) begin
      r = '0;
    end else if (s > CHAN_MAX) begin
      r = '1;
    end else begin
      r = s[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/convolution_3x3_rgb_filter_top.sv
// top level of the 3x3 rgb convolution filter
// Takes one pixel per clock and gives at most one filtered pixel per clock while the output
// is not stalled. The result for pixel (x,y) is computed when the input reaches raster
// position y*W+x+W+1, so a frame is drained by W+1 flush items; the result then passes the
// registered line memory read, window, products, column sums and output, later when stalled.
// Both line memories are read and rewritten at the same column for every pixel, with a
// one-deep bypass for back-to-back pixels at one column; they need no clearing after reset.
// A stall on the output holds the whole pipeline and drops s_axis_tready in the same cycle.
module convolution_3x3_rgb_filter_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int COMPONENTS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [c3f_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [c3f_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // red_in, green_in, blue_in
  input  logic [1:0]                    s_axis_tuser,   // first_of_frame, flush (pixel taken as zero)
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // red_out, green_out, blue_out
  output logic                          m_axis_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = (CW + 1 > c3f_pkg::DIM_W) ? CW + 1 : c3f_pkg::DIM_W;
  localparam logic [DW-1:0] MAXW = DW'(MAX_WIDTH);
  localparam int RW = c3f_pkg::DIM_W;
  localparam int KS = c3f_pkg::KSIZE;
  localparam int CH = c3f_pkg::CH_W;

  // configuration
  logic [RW-1:0]                width_q, height_q;
  logic [KS-1:0][c3f_pkg::CFG_W-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= c3f_pkg::WIDTH_RST;
      height_q  <= c3f_pkg::HEIGHT_RST;
      coef_q[0] <= c3f_pkg::COEF_TOP_RST;
      coef_q[1] <= c3f_pkg::COEF_MID_RST;
      coef_q[2] <= c3f_pkg::COEF_BOT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        c3f_pkg::REG_WIDTH:    width_q   <= cfg_wdata_i[RW-1:0];
        c3f_pkg::REG_HEIGHT:   height_q  <= cfg_wdata_i[RW-1:0];
        c3f_pkg::REG_COEF_TOP: coef_q[0] <= cfg_wdata_i;
        c3f_pkg::REG_COEF_MID: coef_q[1] <= cfg_wdata_i;
        c3f_pkg::REG_COEF_BOT: coef_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w_zero, w_eff;
  logic [RW-1:0] h_zero, h_eff;

  assign w_zero = (width_q == '0) ? DW'(1) : DW'(width_q);
  assign w_eff  = (w_zero > MAXW) ? MAXW : w_zero;
  assign h_zero = (height_q == '0) ? RW'(1) : height_q;
  assign h_eff  = (h_zero > c3f_pkg::ROW_LIMIT) ? c3f_pkg::ROW_LIMIT : h_zero;

  // handshake and position counters
  logic en, acc;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  logic [CW-1:0] col_q, col_d, base_col;
  logic [RW-1:0] row_q, row_d, base_row;

  assign base_col = s_axis_tuser[1] ? '0 : col_q;
  assign base_row = s_axis_tuser[1] ? '0 : row_q;

  always_comb begin
    if (DW'(base_col) + DW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (base_row < c3f_pkg::ROW_SAT) ? base_row + RW'(1) : base_row;
    end else begin
      col_d = base_col + CW'(1);
      row_d = base_row;
    end
  end

  // stage 1: line memory access
  logic          v1_q;
  logic [CW-1:0] c1_q;
  logic [RW-1:0] r1_q;
  c3f_pkg::pix_t pix1_q;
  c3f_pkg::pix_t up_pix, lo_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q   <= base_col;
      r1_q   <= base_row;
      pix1_q <= s_axis_tuser[0] ? '0 : s_axis_tdata;
    end
  end

  c3f_linebuf #(
    .DEPTH(MAX_WIDTH)
  ) u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .rd_addr_i(base_col),
    .wr_en_i  (v1_q),
    .wr_addr_i(c1_q),
    .wr_pix_i (pix1_q),
    .up_o     (up_pix),
    .lo_o     (lo_pix)
  );

  // output position and border test
  logic [DW-1:0]       x1;
  logic signed [RW:0]  y1;
  logic                produce1, last1;
  c3f_pkg::tap_mask_t  mask1;

  always_comb begin
    if (c1_q != '0) begin
      x1 = DW'(c1_q) - DW'(1);
      y1 = $signed({1'b0, r1_q}) - (RW + 1)'(1);
    end else begin
      x1 = w_eff - DW'(1);
      y1 = $signed({1'b0, r1_q}) - (RW + 1)'(2);
    end
    produce1   = v1_q && !y1[RW] && (y1[RW-1:0] < h_eff) && (x1 < w_eff);
    mask1.left  = (x1 != '0);
    mask1.right = ((x1 + DW'(1)) < w_eff);
    mask1.up    = (y1 != '0);
    mask1.down  = (({1'b0, y1[RW-1:0]} + (RW + 1)'(1)) < {1'b0, h_eff});
    last1       = (x1 == w_eff - DW'(1)) && (y1[RW-1:0] == h_eff - RW'(1));
  end

  // stage 2: window
  logic [KS-1:0][KS-1:0][c3f_pkg::PIX_W-1:0] win_q;
  logic               v2_q, v3_q, v4_q;
  logic               last2_q, last3_q, last4_q;
  c3f_pkg::tap_mask_t mask2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
      last4_q <= 1'b0;
      mask2_q <= '0;
    end else if (en) begin
      if (v1_q) begin
        win_q[0]    <= win_q[1];
        win_q[1]    <= win_q[2];
        win_q[2][0] <= up_pix;
        win_q[2][1] <= lo_pix;
        win_q[2][2] <= pix1_q;
      end
      v2_q    <= produce1;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      last2_q <= last1;
      last3_q <= last2_q;
      last4_q <= last3_q;
      mask2_q <= mask1;
    end
  end

  // tap coefficients, flipped and masked at the border
  logic [c3f_pkg::TAPS-1:0][CH-1:0] tap_coef;
  logic [c3f_pkg::NUM_CH-1:0][c3f_pkg::TAPS-1:0][CH-1:0] lane_pix;

  always_comb begin
    logic col_on, row_on;
    for (int a = 0; a < KS; a++) begin
      for (int b = 0; b < KS; b++) begin
        col_on = (a == 0) ? mask2_q.left : ((a == KS - 1) ? mask2_q.right : 1'b1);
        row_on = (b == 0) ? mask2_q.up   : ((b == KS - 1) ? mask2_q.down  : 1'b1);
        tap_coef[a * KS + b] = (col_on && row_on) ? coef_q[KS - 1 - b][CH * (KS - 1 - a) +: CH]
                                                  : '0;
        // taps outside the image also carry zero pixels
        for (int k = 0; k < c3f_pkg::NUM_CH; k++) begin
          lane_pix[k][a * KS + b] = (col_on && row_on) ? win_q[a][b][CH * k +: CH] : '0;
        end
      end
    end
  end

  // channel lanes
  c3f_pkg::chan_t lane_out [c3f_pkg::NUM_CH];

  for (genvar k = 0; k < c3f_pkg::NUM_CH; k++) begin : g_lane
    if (k < COMPONENTS) begin : g_on
      c3f_lane u_lane (
        .clk_i (clk_i),
        .en_i  (en),
        .pix_i (lane_pix[k]),
        .coef_i(tap_coef),
        .chan_o(lane_out[k])
      );
    end else begin : g_off
      assign lane_out[k] = '0;
    end
  end

  // output register
  logic [c3f_pkg::PIX_W-1:0] out_data_q;
  logic                      out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      out_valid_q <= v4_q;
      out_last_q  <= last4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {lane_out[2], lane_out[1], lane_out[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/c3f_linebuf.sv
// two line memories with read-modify-write per pixel and a one-deep bypass
module c3f_linebuf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  c3f_pkg::pix_t            wr_pix_i,
  output c3f_pkg::pix_t            up_o,
  output c3f_pkg::pix_t            lo_o
);

  c3f_pkg::pix_t upper_mem [DEPTH];
  c3f_pkg::pix_t lower_mem [DEPTH];

  c3f_pkg::pix_t rd_up_q, rd_lo_q;
  c3f_pkg::pix_t fwd_up_q, fwd_lo_q;
  logic          fwd_q;

  // upper row takes what the lower row held, lower row takes the new pixel
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en_i) begin
        upper_mem[wr_addr_i] <= lo_o;
        lower_mem[wr_addr_i] <= wr_pix_i;
      end
      rd_up_q  <= upper_mem[rd_addr_i];
      rd_lo_q  <= lower_mem[rd_addr_i];
      fwd_up_q <= lo_o;
      fwd_lo_q <= wr_pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign up_o = fwd_q ? fwd_up_q : rd_up_q;
  assign lo_o = fwd_q ? fwd_lo_q : rd_lo_q;

endmodule

// File: hw/rtl/c3f_lane.sv
// one channel lane: nine multiplies, column sums, total and clamp
module c3f_lane (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [c3f_pkg::TAPS-1:0][c3f_pkg::CH_W-1:0] pix_i,
  input  logic [c3f_pkg::TAPS-1:0][c3f_pkg::CH_W-1:0] coef_i,
  output c3f_pkg::chan_t                             chan_o
);

  logic signed [c3f_pkg::PROD_W-1:0]   prod_d   [c3f_pkg::TAPS];
  logic signed [c3f_pkg::PROD_W-1:0]   prod_q   [c3f_pkg::TAPS];
  logic signed [c3f_pkg::COLSUM_W-1:0] colsum_d [c3f_pkg::KSIZE];
  logic signed [c3f_pkg::COLSUM_W-1:0] colsum_q [c3f_pkg::KSIZE];
  logic signed [c3f_pkg::SUM_W-1:0]    total;

  always_comb begin
    logic signed [c3f_pkg::PROD_W-1:0] pa, ca;
    for (int t = 0; t < c3f_pkg::TAPS; t++) begin
      pa = $signed({{(c3f_pkg::PROD_W - c3f_pkg::CH_W){1'b0}}, pix_i[t]});
      ca = $signed({{(c3f_pkg::PROD_W - c3f_pkg::CH_W){coef_i[t][c3f_pkg::CH_W-1]}},
                    coef_i[t]});
      prod_d[t] = pa * ca;
    end
  end

  always_comb begin
    for (int a = 0; a < c3f_pkg::KSIZE; a++) begin
      colsum_d[a] = c3f_pkg::COLSUM_W'(prod_q[a * c3f_pkg::KSIZE])
                  + c3f_pkg::COLSUM_W'(prod_q[a * c3f_pkg::KSIZE + 1])
                  + c3f_pkg::COLSUM_W'(prod_q[a * c3f_pkg::KSIZE + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      colsum_q <= colsum_d;
    end
  end

  assign total = c3f_pkg::SUM_W'(colsum_q[0]) + c3f_pkg::SUM_W'(colsum_q[1])
               + c3f_pkg::SUM_W'(colsum_q[2]);

  assign chan_o = c3f_pkg::clamp_chan(total);

endmodule

// File: hw/rtl/c3f_chk.sv
// port checker for the 3x3 rgb convolution filter and its bind
module c3f_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // input side stalls exactly when a result waits
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // a new result is loaded only on a cycle where the pipeline moved
  a_load_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared while pipeline was stalled");

  // no input transfer while a result is stalled
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input transfer during output stall");

endmodule

bind convolution_3x3_rgb_filter_top c3f_chk u_c3f_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
